### src/anrah_pkg.sv
// package: shared types and constants for the file name identifier block
`default_nettype none
package anrah_pkg;

	localparam logic [7:0] ASCII_ZERO   = 8'h30;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;
	localparam logic [1:0] LANE_LAST    = 2'd3;
	localparam logic [2:0] POS_SATURATE = 3'd7;

	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] data;
	} anrah_beat_t;

	// decimal weight of each name position in speech mode; positions 2 and 7 (and beyond) weigh zero
	function automatic logic [16:0] digit_weight(input logic [2:0] pos);
		logic [16:0] w;
		begin
			unique case (pos)
				3'd0:    w = 17'd100000;
				3'd1:    w = 17'd10000;
				3'd3:    w = 17'd1000;
				3'd4:    w = 17'd100;
				3'd5:    w = 17'd10;
				3'd6:    w = 17'd1;
				default: w = 17'd0;
			endcase
			return w;
		end
	endfunction

endpackage
`default_nettype wire

### src/anrah_accum.sv
// name accumulators: rotate-add hash over packed words and weighted digit sum
`default_nettype none
module anrah_accum (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire anrah_pkg::anrah_beat_t beat,
	output logic [31:0]             hash_next,
	output logic [31:0]             digit_next
);
	import anrah_pkg::*;

	logic [23:0] partial_q;
	logic [1:0]  lane_q;
	logic [31:0] hash_q;
	logic [2:0]  pos_q;
	logic [31:0] digit_q;

	logic [7:0]         folded;
	logic [31:0]        word;
	logic               word_done;
	logic signed [8:0]  digit;
	logic signed [26:0] product;

	always_comb begin
		folded = beat.data;
		if (beat.data >= ASCII_LOWER_A && beat.data <= ASCII_LOWER_Z) begin
			folded = beat.data - CASE_OFFSET;
		end
		word      = {8'd0, partial_q} | ({24'd0, folded} << {lane_q, 3'b000});
		word_done = (lane_q == LANE_LAST) || beat.last;
		hash_next = word_done ? ({hash_q[30:0], hash_q[31]} + word) : hash_q;
	end

	// byte minus '0' may go negative, sign extension gives the 32-bit wrap
	always_comb begin
		digit      = $signed({1'b0, beat.data}) - $signed({1'b0, ASCII_ZERO});
		product    = digit * $signed({1'b0, digit_weight(pos_q)});
		digit_next = digit_q + {{5{product[26]}}, product};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			lane_q    <= '0;
			hash_q    <= '0;
			pos_q     <= '0;
			digit_q   <= '0;
		end else if (beat.fire) begin
			if (beat.last) begin
				partial_q <= '0;
				lane_q    <= '0;
				hash_q    <= '0;
				pos_q     <= '0;
				digit_q   <= '0;
			end else begin
				partial_q <= word_done ? 24'd0 : word[23:0];
				lane_q    <= lane_q + 2'd1;
				hash_q    <= hash_next;
				digit_q   <= digit_next;
				if (pos_q != POS_SATURATE) begin
					pos_q <= pos_q + 3'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

### src/archive_name_rotate_add_hash.sv
// top level: file name identifier, byte stream in, one identifier per name out
// output: identifier is registered, valid in the cycle after the last byte beat is accepted
// throughput: one byte beat per cycle; a waiting identifier only stalls input
// while it is not being taken
// reset: asynchronous, clears mode to hash, name state and output valid
`default_nettype none
module archive_name_rotate_add_hash (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        speech_mode,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  name_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      identifier
);
	import anrah_pkg::*;

	logic        mode_q;
	logic        out_valid_q;
	logic [31:0] ident_q;
	anrah_beat_t beat;
	logic [31:0] hash_next;
	logic [31:0] digit_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign identifier = ident_q;

	assign beat = '{fire: in_valid && in_ready, last: last_byte, data: name_byte};

	anrah_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.hash_next (hash_next),
		.digit_next(digit_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			mode_q <= speech_mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (beat.fire && beat.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (beat.fire && beat.last) begin
			ident_q <= mode_q ? digit_next : hash_next;
		end
	end

endmodule
`default_nettype wire
